/* sv/itda_pkg.sv */
// ============================================================================
// itda_pkg - shared constants for the decimal ASCII converter
// Character codes and sequencer state codes.
// ============================================================================
package itda_pkg;

    typedef logic [6:0] t_char;
    typedef logic [3:0] t_digit;
    typedef logic [1:0] t_state;

    localparam t_char CH_ZERO  = 7'd48;
    localparam t_char CH_MINUS = 7'd45;

    localparam t_digit DIGIT_NINE = 4'd9;
    localparam t_digit DIGIT_FIVE = 4'd5;
    localparam t_digit DIGIT_ADJ  = 4'd3;

    localparam t_state ST_IDLE = 2'd0;
    localparam t_state ST_CONV = 2'd1;
    localparam t_state ST_SIGN = 2'd2;
    localparam t_state ST_EMIT = 2'd3;

endpackage

/* sv/itda_dabble.sv */
// ============================================================================
// itda_dabble - one shift-and-add-3 step
// Adjusts every BCD digit of five or more by three, then shifts the whole
// BCD word left by one, taking in the next magnitude bit.
// ============================================================================
module itda_dabble
    import itda_pkg::*;
#(
    parameter int NUM_DIGITS = 10
) (
    input  logic [NUM_DIGITS*4-1:0] i_bcd,
    input  logic                    i_bit,
    output logic [NUM_DIGITS*4-1:0] o_bcd
);

    logic [NUM_DIGITS*4-1:0] adj;

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_bcd[k*4 +: 4] >= DIGIT_FIVE) begin
                adj[k*4 +: 4] = i_bcd[k*4 +: 4] + DIGIT_ADJ;
            end else begin
                adj[k*4 +: 4] = i_bcd[k*4 +: 4];
            end
        end
    end

    // drop the top bit: a digit below eight never carries out
    assign o_bcd = {adj[NUM_DIGITS*4-2:0], i_bit};

endmodule

/* sv/int_to_decimal_ascii.sv */
// ============================================================================
// int_to_decimal_ascii - signed binary to decimal ASCII text
// Sequence: after the transfer the value passes through the shift-add-3
//   conversion of every magnitude bit, then a sign state for a negative value,
//   then a walk of the BCD digits from the top; each character leaves through
//   the output register.
// The block takes no new value until the last digit of the previous one has
//   been walked; the single shared shift-add-3 step serves every magnitude bit.
// Reset: synchronous, active low; returns to idle and drops the strobe.
// Results are strobed for one cycle each; the receiver cannot stall them.
// ============================================================================
module int_to_decimal_ascii
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_strobe,
    output logic [6:0]             o_ascii_char,
    output logic                   o_last
);

    // Digits needed for 2^(VALUE_WIDTH-1); 0.3*W + 1 covers every width
    // in range.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    // Counter holds the larger of the two loop lengths; the width is
    // always larger than the digit count.
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    t_state                  r_state,  n_state;
    logic [VALUE_WIDTH-1:0]  r_mag,    n_mag;
    logic [BCD_W-1:0]        r_bcd,    n_bcd;
    logic [CNT_W-1:0]        r_cnt,    n_cnt;
    logic                    r_neg,    n_neg;
    logic                    r_started, n_started;
    logic                    r_strobe, n_strobe;
    t_char                   r_char,   n_char;
    logic                    r_last,   n_last;

    logic [BCD_W-1:0]        step_bcd;
    t_digit                  top_digit;
    logic                    cnt_one;

    // Shared conversion step: one magnitude bit per cycle.
    itda_dabble #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_mag[VALUE_WIDTH-1]),
        .o_bcd (step_bcd)
    );

    assign top_digit = r_bcd[BCD_W-1 -: 4];
    assign cnt_one   = (r_cnt == CNT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_started = r_started;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_last    = r_last;

        case (r_state)
            ST_IDLE: begin
                // Capture the value and take its unsigned magnitude; the
                // most negative value negates onto itself, which is right.
                if (start) begin
                    n_neg     = i_value[VALUE_WIDTH-1];
                    n_mag     = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd     = '0;
                    n_cnt     = CNT_W'(VALUE_WIDTH);
                    n_started = 1'b0;
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                // Advance the shift-add-3 conversion by one bit.
                n_bcd = step_bcd;
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (cnt_one) begin
                    n_cnt   = CNT_W'(NUM_DIGITS);
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CH_MINUS;
                n_last   = 1'b0;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                // Walk digits from the top; drop leading zeros but always
                // send the units digit, so zero gives a single '0'.
                if (top_digit != 4'd0 || r_started || cnt_one) begin
                    n_strobe  = 1'b1;
                    n_char    = CH_ZERO + {3'b000, top_digit};
                    n_last    = cnt_one;
                    n_started = 1'b1;
                end
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                n_cnt = r_cnt - 1'b1;
                if (cnt_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

    // An accepted transfer always leaves the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not start conversion");

    // No character leaves while the shift-add-3 loop is still running.
    a_conv_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !o_strobe)
        else $error("strobe during conversion");

    // The final character ends the run: nothing follows it directly.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character after last");

    // Only a minus sign or a decimal digit is ever sent.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_ascii_char == CH_MINUS ||
                      (o_ascii_char >= CH_ZERO &&
                       o_ascii_char <= CH_ZERO + {3'b000, DIGIT_NINE})))
        else $error("illegal character code");

    // The sign is never the final character.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_ascii_char == CH_MINUS) |-> !o_last)
        else $error("minus flagged as last");

endmodule

/* test/int_to_decimal_ascii_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// int_to_decimal_ascii_checker - character stream checker
// Watches the value and character channels of the decimal ASCII converter,
// spells each accepted value into the characters it should produce, and
// compares every strobed character and its last flag against the oldest one
// still due.
// ============================================================================
module int_to_decimal_ascii_checker
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_strobe,
    input  logic [6:0]             i_ascii_char,
    input  logic                   i_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_chars_seen
);

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_char;

    t_text_char text_due[$];
    t_text_char due;
    int         fails      = 0;
    int         pending    = 0;
    int         chars_seen = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_chars_seen = chars_seen;

    // Append the decimal text of one two's complement value, sign first.
    function automatic void spell_decimal(input logic [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] magnitude;
        t_char                  digits[$];
        logic                   negative;
        negative  = value[VALUE_WIDTH-1];
        // the most negative value wraps to its own unsigned magnitude here
        magnitude = negative ? (~value + 1'b1) : value;
        do begin
            digits.push_front(CH_ZERO + t_char'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative)
            text_due.push_back('{CH_MINUS, 1'b0});
        foreach (digits[k])
            text_due.push_back('{digits[k], (k == digits.size() - 1)});
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_strobe) begin
                if (text_due.size() == 0) begin
                    $error("unexpected character %0d (last %0d)", i_ascii_char, i_last);
                    fails++;
                end else begin
                    due = text_due.pop_front();
                    chars_seen++;
                    if (i_ascii_char !== due.ch) begin
                        $error("ascii_char: expected %0d, actual %0d", due.ch, i_ascii_char);
                        fails++;
                    end
                    if (i_last !== due.last) begin
                        $error("last: expected %0d, actual %0d", due.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy)
                spell_decimal(i_value);
            pending = text_due.size();
        end
    end

endmodule

/* test/int_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// int_to_decimal_ascii_tb - testbench for the decimal ASCII converter
// Drives signed 32-bit values through the start/busy command port: a directed
// set of extremes and digit-count boundaries, then three random phases with
// different amounts of sender idling. A separate checker predicts and checks
// every character; this module makes stimulus and gives the verdict.
// ============================================================================
module int_to_decimal_ascii_tb;
    import itda_pkg::*;

    localparam int VALUE_WIDTH = 32;
    // Slowest run is roughly 500 values, each a full conversion followed by the
    // longest sender gap; allow many times that.
    localparam int CYCLE_LIMIT = 500000;
    // Settle at the end for longer than the longest conversion.
    localparam int SETTLE_CYCLES = 64;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start   = 1'b0;
    logic                   busy;
    logic [VALUE_WIDTH-1:0] i_value = '0;
    logic                   o_strobe;
    logic [6:0]             o_ascii_char;
    logic                   o_last;

    int fail_count;
    int pending;
    int chars_seen;
    int cycles      = 0;
    int values_sent = 0;
    int negatives   = 0;
    int zeros       = 0;

    int_to_decimal_ascii #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    int_to_decimal_ascii_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_text_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_strobe     (o_strobe),
        .i_ascii_char (o_ascii_char),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_chars_seen (chars_seen)
    );

    // 20 ns clock: ten high, ten low.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: end the run if the stream stalls for good.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d characters still due",
                     cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one value at the falling edge and hold it until a rising edge
    // sees busy low. Start stays high on return, so a following transfer
    // goes back to back without a gap.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
        @(negedge i_clk);
        start   = 1'b1;
        i_value = value;
        do @(posedge i_clk); while (busy);
        values_sent++;
        if (value[VALUE_WIDTH-1])
            negatives++;
        if (value == '0)
            zeros++;
    endtask

    // Drop start for a random stretch; scribble on the value bus meanwhile
    // so that the converter is seen to ignore it.
    task automatic sender_gap(input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 48);
            @(negedge i_clk);
            start   = 1'b0;
            i_value = $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every character due has been strobed out.
    task automatic drain_text();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Random value, weighted towards the interesting corners: short numbers,
    // powers of ten either side (digit count changes), the two extremes, and
    // otherwise full-range patterns so every bit toggles both ways.
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] power;
        int                     sel;
        power = 1;
        sel   = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
                return VALUE_WIDTH'($urandom_range(0, 2000)) - VALUE_WIDTH'(1000);
            end
            3: begin
                repeat ($urandom_range(0, 9)) power = power * 10;
                power = power + VALUE_WIDTH'($urandom_range(0, 2)) - VALUE_WIDTH'(1);
                return $urandom_range(0, 1) ? -power : power;
            end
            4: begin
                if ($urandom_range(0, 1))
                    return 32'h8000_0000 + VALUE_WIDTH'($urandom_range(0, 3));
                else
                    return 32'h7FFF_FFFF - VALUE_WIDTH'($urandom_range(0, 3));
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic random_phase(input int count, input int idle_pct);
        repeat (count) begin
            send_value(random_value());
            sender_gap(idle_pct);
        end
    endtask

    initial begin
        // Hold reset from the start, then release it at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero, single digits, digit-count boundaries, extremes,
        // and the most negative value, whose negation overflows.
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd5);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(-32'sd7);
        send_value(32'd42);
        send_value(32'd123456789);
        send_value(-32'sd1234567890);
        send_value(32'd999999999);
        send_value(-32'sd999999999);
        send_value(32'd1000000000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0001);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(32'd0);

        // Pause until the directed run has fully drained before going random.
        drain_text();

        // Light sender idling, then heavy idling, then none at all.
        random_phase(160, 25);
        drain_text();
        random_phase(160, 70);
        drain_text();
        random_phase(160, 0);

        // Wait for the tail, then let the converter settle.
        drain_text();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d values (%0d negative, %0d zero) in %0d cycles,",
                 values_sent, negatives, zeros, cycles);
        $display("checking %0d characters under light, heavy and no sender idling.",
                 chars_seen);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
sv/itda_pkg.sv
sv/itda_dabble.sv
sv/int_to_decimal_ascii.sv
test/int_to_decimal_ascii_checker.sv
test/int_to_decimal_ascii_tb.sv
